/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue modules
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int ENTRY_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] item_value;
  } spq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [POS_W-1:0]          position;
    logic [ENTRY_W-1:0]        entry_count;
    logic signed [VALUE_W-1:0] head_value;
    logic                      head_valid;
  } spq_out_t;

  // operation broadcast to every slot
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] key;
  } spq_op_t;

  // what a slot shows its neighbors and the control
  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      occ;
    logic                      gt;
    logic                      eq;
  } spq_slot_t;

endpackage

/* rtl/core/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// sorted priority queue held in a chain of slots, greatest value at the head
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_stall / in_data carries a command (insert,
//   remove, find) and a signed 32-bit value; every transaction yields exactly
//   one result transaction on out_valid / out_stall / out_data
//   the result carries status, position from the head, entry count and the
//   head value after the operation
//   execution: an accepted command is latched; when the output register is
//   free, every slot compares the latched value in that cycle, the slots not
//   greater shift one place on insert or remove, and the result is registered
//   throughput: one transaction per cycle while out_stall does not hold a
//   waiting result; the broadcast compare and shift covers the whole slot chain
//   stall: while out_stall holds a waiting result, one more transaction is
//   accepted and held, then in_stall rises until the result is taken
//   reset: rst_n low, sampled at the clock, empties the queue and drops both valids
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                      op_valid_r;
  spq_in_t                   op_r;
  logic                      out_valid_r;
  spq_out_t                  out_data_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;

  logic                      exec;
  logic                      full;
  logic                      found;
  spq_op_t                   op;
  spq_slot_t                 stat_vec [DEPTH];
  logic signed [VALUE_W-1:0] val_nxt_vec [DEPTH];
  logic [DEPTH-1:0]          gt_vec;
  logic [DEPTH-1:0]          eq_vec;
  logic [DEPTH-1:0]          occ_vec;
  logic [PW-1:0]             enc_pos;
  spq_out_t                  res;
  spq_slot_t                 head_edge;
  spq_slot_t                 tail_edge;

  assign exec     = op_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = op_valid_r && !exec;
  assign full     = (count_r == CW'(DEPTH));
  assign found    = |eq_vec;

  assign op.key = op_r.item_value;
  assign op.ins = exec && (op_r.command == CMD_INSERT) && !full;
  assign op.rem = exec && (op_r.command == CMD_REMOVE) && found;

  assign head_edge = '{val: '0, occ: 1'b1, gt: 1'b1, eq: 1'b0};
  assign tail_edge = '{val: '0, occ: 1'b0, gt: 1'b0, eq: 1'b0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    spq_cell u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .left_stat  ((g == 0) ? head_edge : stat_vec[(g == 0) ? 0 : g-1]),
      .right_stat ((g == DEPTH-1) ? tail_edge : stat_vec[(g == DEPTH-1) ? g : g+1]),
      .stat       (stat_vec[g]),
      .val_nxt_o  (val_nxt_vec[g])
    );
    assign gt_vec[g]  = stat_vec[g].gt;
    assign eq_vec[g]  = stat_vec[g].eq;
    assign occ_vec[g] = stat_vec[g].occ;
  end

  spq_pos_enc #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_pos_enc (
    .gt_vec (gt_vec),
    .pos    (enc_pos)
  );

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    case (op_r.command) inside
      CMD_INSERT: res.status = full ? ST_FULL : ST_DONE;
      CMD_REMOVE, CMD_FIND: res.status = found ? ST_DONE : ST_NOT_FOUND;
      default: res.status = ST_NOT_FOUND;
    endcase
    res.position    = (res.status == ST_DONE) ? POS_W'(enc_pos) : '0;
    res.entry_count = ENTRY_W'(count_nxt);
    res.head_valid  = (count_nxt != '0);
    res.head_value  = res.head_valid ? val_nxt_vec[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        op_valid_r <= 1'b1;
      end else if (exec) begin
        op_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r <= in_data;
    end
    if (exec) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the number of occupied slots always equals the count (they form a prefix from the head)
  a_count_occ: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == count_r)
    else $error("slot occupancy does not match count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count exceeds depth");

  // sorted order keeps the greater-than flags a thermometer from the head
  a_gt_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    ((gt_vec >> 1) & ~gt_vec) == '0)
    else $error("slot order broken");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed transaction produced no result");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow count");

endmodule

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds a value, compares it with the broadcast
// key and shifts toward the tail on insert or toward the head on remove
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_op_t                   op,
  input  spq_slot_t                 left_stat,
  input  spq_slot_t                 right_stat,
  output spq_slot_t                 stat,
  output logic signed [VALUE_W-1:0] val_nxt_o
);

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;
  logic                      occ_r;
  logic                      occ_nxt;
  logic                      gt;
  logic                      eq;

  always_comb begin
    gt      = occ_r && (val_r > op.key);
    eq      = occ_r && (val_r == op.key);
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (op.ins && !gt) begin
      val_nxt = left_stat.gt ? op.key : left_stat.val;
      occ_nxt = occ_r | left_stat.occ;
    end else if (op.rem && !gt) begin
      val_nxt = right_stat.val;
      occ_nxt = right_stat.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign stat.val  = val_r;
  assign stat.occ  = occ_r;
  assign stat.gt   = gt;
  assign stat.eq   = eq;
  assign val_nxt_o = val_nxt;

endmodule

/* rtl/core/spq_pos_enc.sv */
// ----------------------------------------------------------------------------
// spq_pos_enc
// turns the thermometer of greater-than flags into the index of the first
// slot that is not greater
// ----------------------------------------------------------------------------
module spq_pos_enc
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PW    = 4
)
(
  input  logic [DEPTH-1:0] gt_vec,
  output logic [PW-1:0]    pos
);

  logic [DEPTH-1:0] edge_vec;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        edge_vec[i] = !gt_vec[i];
      end else begin
        edge_vec[i] = !gt_vec[i] && gt_vec[i-1];
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (edge_vec[i] ? PW'(i) : '0);
    end
  end

endmodule
